[rtl/ntq_pkg.sv]
// ----------------------------------------------------------------------------
// ntq_pkg: shared types and constants of the nonce chained transaction queue
// Opcodes, status codes, sequencer states and defaults used by the queue.
// ----------------------------------------------------------------------------
package ntq_pkg;

  localparam int unsigned QueueDepth = 16;

  localparam logic [4:0] MaxPendingReset = 5'd9;

  typedef enum logic [2:0] {
    OP_PUSH        = 3'd0,
    OP_POP_FOLLOW  = 3'd1,
    OP_POP_AHEAD   = 3'd2,
    OP_TRIM        = 3'd3,
    OP_FIND        = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_EXPIRED   = 3'd2,
    STS_GAP       = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAIL_RD,
    ST_TAIL_CMP,
    ST_PUSH_WR,
    ST_SCAN,
    ST_HEAD_RD,
    ST_HEAD_CAP
  } state_e;

  typedef struct packed {
    logic [255:0] hash;
    logic [63:0]  nonce;
    logic [63:0]  prev_nonce;
  } entry_t;

endpackage

[rtl/ntq_if.sv]
// ----------------------------------------------------------------------------
// ntq_if: request and response channels of the nonce chained transaction queue
// Valid/ready channels; a transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ntq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] hash_w0;
  logic [63:0] hash_w1;
  logic [63:0] hash_w2;
  logic [63:0] hash_w3;
  logic [63:0] push_nonce;
  logic [63:0] prev_nonce;
  logic [63:0] confirmed_nonce;

  modport source (
    output valid, op, hash_w0, hash_w1, hash_w2, hash_w3, push_nonce, prev_nonce,
           confirmed_nonce,
    input  ready
  );

  modport sink (
    input  valid, op, hash_w0, hash_w1, hash_w2, hash_w3, push_nonce, prev_nonce,
           confirmed_nonce,
    output ready
  );
endinterface

interface ntq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] found_nonce;
  logic [63:0] found_prev_nonce;
  logic [4:0]  removed_count;
  logic [4:0]  pending_count;
  logic [63:0] head_prev_nonce;

  modport source (
    output valid, status, found_nonce, found_prev_nonce, removed_count, pending_count,
           head_prev_nonce,
    input  ready
  );

  modport sink (
    input  valid, status, found_nonce, found_prev_nonce, removed_count, pending_count,
           head_prev_nonce,
    output ready
  );
endinterface

[rtl/nonce_chained_tx_queue.sv]
// ----------------------------------------------------------------------------
// nonce_chained_tx_queue: pending transaction queue of one sender
// Ring of QUEUE_DEPTH entries in a one-read one-write memory, walked by a
// sequencer.
// ----------------------------------------------------------------------------
// One request transaction in, one response transaction out. Entries live in a
// ring memory with one write and one registered read port, and all work goes
// through that read port. A request ends with the cycle that loads the
// response; the next request can be accepted in the cycle after. A push steps
// through accept, tail read, nonce compare, write, head read and load; into an
// empty queue it skips the tail read and compare, if the nonce check refuses
// it the write is skipped, and a full queue or an unused opcode goes from accept
// straight to head read and load. Pop, find and trim walk the ring from the
// head one entry a cycle and stop at the first match (or the first nonce above
// the confirmed nonce for trim), visiting at most QUEUE_DEPTH entries, then
// read the head and load. The load waits while the output register stays full.
// The block takes no new request until the response of the current one is
// loaded into the output register; it then accepts again while that response
// waits. The user must write max_pending through cfg_we_i/cfg_wdata_i while
// the block is idle; the block itself has no check for this.
module nonce_chained_tx_queue #(
  parameter int unsigned QUEUE_DEPTH = ntq_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_wdata_i,
  ntq_req_if.sink          req_i,
  ntq_rsp_if.source        rsp_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Ring slot of a position counted from the head; the sum stays below twice
  // the depth, so one compare and subtract wraps it.
  function automatic logic [IdxW-1:0] slot_f(input logic [IdxW-1:0] head,
                                             input logic [CntW-1:0] pos);
    logic [CntW:0] sum;
    sum = (CntW+1)'(head) + (CntW+1)'(pos);
    if (sum >= (CntW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CntW+1)'(QUEUE_DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  ntq_pkg::state_e  state_q, state_d;
  logic [4:0]       max_pending_q;

  logic [2:0]       op_q, op_d;
  logic [255:0]     hash_q, hash_d;
  logic [63:0]      push_nonce_q, push_nonce_d;
  logic [63:0]      prev_nonce_q, prev_nonce_d;
  logic [63:0]      conf_nonce_q, conf_nonce_d;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic             chk_vld_q, chk_vld_d;
  logic [CntW-1:0]  chk_pos_q, chk_pos_d;

  ntq_pkg::status_e status_q, status_d;
  logic [63:0]      fn_q, fn_d;
  logic [63:0]      fp_q, fp_d;
  logic [CntW-1:0]  removed_q, removed_d;

  logic             out_valid_q, out_valid_d;
  logic             rsp_load;
  logic [2:0]       o_status_q;
  logic [63:0]      o_fn_q;
  logic [63:0]      o_fp_q;
  logic [4:0]       o_removed_q;
  logic [4:0]       o_pending_q;
  logic [63:0]      o_head_prev_q;

  ntq_pkg::entry_t  mem_q [QUEUE_DEPTH];
  ntq_pkg::entry_t  rd_data_q;
  ntq_pkg::entry_t  wr_data;
  logic             mem_we;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_addr;

  logic             is_full;
  logic             is_trim;
  logic             scan_hit;
  logic             scan_last;
  logic [CntW-1:0]  trim_pos;

  assign req_i.ready = (state_q == ntq_pkg::ST_IDLE);

  assign is_full = (32'(cnt_q) >= 32'(max_pending_q)) || (32'(cnt_q) >= 32'(QUEUE_DEPTH));
  assign is_trim = (op_q == ntq_pkg::OP_TRIM);

  // Trim stops at the first nonce above the confirmed one; the others stop at
  // the first matching hash.
  assign scan_hit  = chk_vld_q && (is_trim ? (rd_data_q.nonce > conf_nonce_q)
                                           : (rd_data_q.hash == hash_q));
  assign scan_last = !scan_hit && (pos_q == cnt_q);
  assign trim_pos  = scan_hit ? chk_pos_q : cnt_q;

  assign wr_addr = slot_f(head_q, cnt_q);
  assign wr_data = '{hash: hash_q, nonce: push_nonce_q, prev_nonce: prev_nonce_q};

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    hash_d       = hash_q;
    push_nonce_d = push_nonce_q;
    prev_nonce_d = prev_nonce_q;
    conf_nonce_d = conf_nonce_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    pos_d        = pos_q;
    chk_vld_d    = chk_vld_q;
    chk_pos_d    = chk_pos_q;
    status_d     = status_q;
    fn_d         = fn_q;
    fp_d         = fp_q;
    removed_d    = removed_q;
    mem_we       = 1'b0;
    rd_addr      = head_q;
    rsp_load     = 1'b0;

    unique case (state_q)
      ntq_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          op_d         = req_i.op;
          hash_d       = {req_i.hash_w3, req_i.hash_w2, req_i.hash_w1, req_i.hash_w0};
          push_nonce_d = req_i.push_nonce;
          prev_nonce_d = req_i.prev_nonce;
          conf_nonce_d = req_i.confirmed_nonce;
          pos_d        = '0;
          chk_vld_d    = 1'b0;
          status_d     = ntq_pkg::STS_OK;
          fn_d         = '0;
          fp_d         = '0;
          removed_d    = '0;
          case (req_i.op) inside
            ntq_pkg::OP_PUSH: begin
              if (is_full) begin
                status_d = ntq_pkg::STS_FULL;
                state_d  = ntq_pkg::ST_HEAD_RD;
              end else if (cnt_q == '0) begin
                state_d = ntq_pkg::ST_PUSH_WR;
              end else begin
                state_d = ntq_pkg::ST_TAIL_RD;
              end
            end
            ntq_pkg::OP_POP_FOLLOW, ntq_pkg::OP_POP_AHEAD, ntq_pkg::OP_TRIM,
            ntq_pkg::OP_FIND: begin
              state_d = ntq_pkg::ST_SCAN;
            end
            default: begin
              state_d = ntq_pkg::ST_HEAD_RD;
            end
          endcase
        end
      end

      ntq_pkg::ST_TAIL_RD: begin
        rd_addr = slot_f(head_q, cnt_q - CntW'(1));
        state_d = ntq_pkg::ST_TAIL_CMP;
      end

      ntq_pkg::ST_TAIL_CMP: begin
        if (prev_nonce_q < rd_data_q.nonce) begin
          status_d = ntq_pkg::STS_EXPIRED;
          state_d  = ntq_pkg::ST_HEAD_RD;
        end else if (prev_nonce_q > rd_data_q.nonce) begin
          status_d = ntq_pkg::STS_GAP;
          state_d  = ntq_pkg::ST_HEAD_RD;
        end else begin
          state_d = ntq_pkg::ST_PUSH_WR;
        end
      end

      ntq_pkg::ST_PUSH_WR: begin
        mem_we  = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
        state_d = ntq_pkg::ST_HEAD_RD;
      end

      ntq_pkg::ST_SCAN: begin
        // Issue the next read while the previous entry is checked.
        if (pos_q != cnt_q) begin
          rd_addr   = slot_f(head_q, pos_q);
          pos_d     = pos_q + CntW'(1);
          chk_vld_d = 1'b1;
          chk_pos_d = pos_q;
        end else begin
          chk_vld_d = 1'b0;
        end
        if (scan_hit || scan_last) begin
          state_d = ntq_pkg::ST_HEAD_RD;
          if (is_trim) begin
            removed_d = trim_pos;
            cnt_d     = cnt_q - trim_pos;
            head_d    = slot_f(head_q, trim_pos);
          end else if (scan_hit) begin
            fn_d = rd_data_q.nonce;
            fp_d = rd_data_q.prev_nonce;
            if (op_q == ntq_pkg::OP_POP_FOLLOW) begin
              removed_d = cnt_q - chk_pos_q;
              cnt_d     = chk_pos_q;
            end else if (op_q == ntq_pkg::OP_POP_AHEAD) begin
              removed_d = chk_pos_q + CntW'(1);
              cnt_d     = cnt_q - chk_pos_q - CntW'(1);
              head_d    = slot_f(head_q, chk_pos_q + CntW'(1));
            end
          end else begin
            status_d = ntq_pkg::STS_NOT_FOUND;
          end
        end
      end

      ntq_pkg::ST_HEAD_RD: begin
        state_d = ntq_pkg::ST_HEAD_CAP;
      end

      ntq_pkg::ST_HEAD_CAP: begin
        // Hold the head read until the output register is free.
        if (!out_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ntq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ntq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ntq_pkg::ST_IDLE;
      max_pending_q <= ntq_pkg::MaxPendingReset;
      cnt_q         <= '0;
      head_q        <= '0;
      pos_q         <= '0;
      chk_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      pos_q       <= pos_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_pending_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    hash_q       <= hash_d;
    push_nonce_q <= push_nonce_d;
    prev_nonce_q <= prev_nonce_d;
    conf_nonce_q <= conf_nonce_d;
    chk_pos_q    <= chk_pos_d;
    status_q     <= status_d;
    fn_q         <= fn_d;
    fp_q         <= fp_d;
    removed_q    <= removed_d;
    if (rsp_load) begin
      o_status_q    <= status_q;
      o_fn_q        <= fn_q;
      o_fp_q        <= fp_q;
      o_removed_q   <= 5'(removed_q);
      o_pending_q   <= 5'(cnt_q);
      o_head_prev_q <= (cnt_q != '0) ? rd_data_q.prev_nonce : 64'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = o_status_q;
  assign rsp_o.found_nonce      = o_fn_q;
  assign rsp_o.found_prev_nonce = o_fp_q;
  assign rsp_o.removed_count    = o_removed_q;
  assign rsp_o.pending_count    = o_pending_q;
  assign rsp_o.head_prev_nonce  = o_head_prev_q;

endmodule
